>>> rtl/ramd_pkg.sv
package ramd_pkg;

  localparam int LEN_BITS = 24;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_SKIP = 2'd1,
    PH_RUN  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_ZERO_SIZE  = 3'd1,
    ERR_TRAILING   = 3'd2,
    ERR_NO_SKIP    = 3'd3,
    ERR_SKIP_BEYOND = 3'd4,
    ERR_RUN_BEYOND = 3'd5,
    ERR_TRUNCATED  = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LENGTH = 2'd2
  } reg_idx_t;

  localparam logic [7:0] CMD_SKIP = 8'd255;

  typedef struct packed {
    logic                is_status;
    logic [31:0]         pixel_index;
    logic [7:0]          alpha_value;
    logic [2:0]          error_code;
    logic [LEN_BITS-1:0] bytes_used;
    logic [31:0]         end_cursor;
    logic                last_result;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

>>> rtl/ramd_core.sv
module ramd_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [7:0]                   in_byte,
  input  logic                         room,
  input  logic [31:0]                  pix_total,
  input  logic [ramd_pkg::LEN_BITS-1:0] stream_len,
  output logic                         take,
  output ramd_pkg::push_t              push
);
  import ramd_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [7:0]          run_r, run_nxt;
  logic [31:0]         cursor_r, cursor_nxt;
  logic [LEN_BITS-1:0] seen_r, seen_nxt;

  logic [31:0]         pix_left;
  logic [LEN_BITS-1:0] seen_inc, bytes_left;
  logic                b_gt_pix, b_gt_bytes;
  logic                stop, pix_vld;
  err_t                stop_err;
  res_t                pix_res, stat_res;

  assign take = in_vld & room;

  always_comb begin
    pix_left   = (cursor_r >= pix_total) ? 32'd0 : pix_total - cursor_r;
    seen_inc   = seen_r + 1'b1;
    bytes_left = (seen_inc >= stream_len) ? '0 : stream_len - seen_inc;
    b_gt_pix   = 32'(in_byte) > pix_left;
    b_gt_bytes = LEN_BITS'(in_byte) > bytes_left;
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    run_nxt    = run_r;
    cursor_nxt = cursor_r;
    seen_nxt   = seen_r;
    stop       = 1'b0;
    stop_err   = ERR_OK;
    if (take) begin
      unique case (phase_r)
        PH_CMD: begin
          if (pix_total == 32'd0) begin
            stop = 1'b1; stop_err = ERR_ZERO_SIZE;
          end else if (seen_r >= stream_len) begin
            stop = 1'b1; stop_err = ERR_OK;
          end else if (cursor_r >= pix_total) begin
            stop = 1'b1; stop_err = ERR_TRAILING;
          end else begin
            seen_nxt = seen_inc;
            if (in_byte == CMD_SKIP) begin
              if (seen_inc >= stream_len) begin
                stop = 1'b1; stop_err = ERR_NO_SKIP;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end else if (b_gt_pix) begin
              stop = 1'b1; stop_err = ERR_RUN_BEYOND;
            end else if (b_gt_bytes) begin
              stop = 1'b1; stop_err = ERR_TRUNCATED;
            end else if (in_byte != 8'd0) begin
              run_nxt   = in_byte;
              phase_nxt = PH_RUN;
            end
          end
        end
        PH_SKIP: begin
          seen_nxt = seen_inc;
          if (b_gt_pix) begin
            stop = 1'b1; stop_err = ERR_SKIP_BEYOND;
          end else begin
            cursor_nxt = cursor_r + 32'(in_byte);
            phase_nxt  = PH_CMD;
          end
        end
        PH_RUN: begin
          seen_nxt   = seen_inc;
          cursor_nxt = cursor_r + 32'd1;
          run_nxt    = run_r - 8'd1;
          if (run_r == 8'd1) phase_nxt = PH_CMD;
        end
        PH_DONE: begin
        end
      endcase
      // stream end after a completed command
      if (!stop && phase_nxt == PH_CMD && seen_nxt >= stream_len) begin
        stop     = 1'b1;
        stop_err = ERR_OK;
      end
      if (stop) phase_nxt = PH_DONE;
    end
  end

  // results
  always_comb begin
    pix_vld = take && (phase_r == PH_RUN);

    pix_res                 = '0;
    pix_res.pixel_index     = cursor_r;
    pix_res.alpha_value     = {in_byte[4:0], in_byte[4:2]};
    pix_res.last_result     = !stop;

    stat_res                 = '0;
    stat_res.is_status       = 1'b1;
    stat_res.error_code      = stop_err;
    stat_res.bytes_used      = seen_nxt;
    stat_res.end_cursor      = cursor_nxt;
    stat_res.last_result     = 1'b1;

    push.cnt    = {1'b0, pix_vld} + {1'b0, stop};
    push.first  = pix_vld ? pix_res : stat_res;
    push.second = stat_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CMD;
      run_r    <= 8'd0;
      cursor_r <= 32'd0;
      seen_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      run_r    <= run_nxt;
      cursor_r <= cursor_nxt;
      seen_r   <= seen_nxt;
    end
  end

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> push.cnt == 2'd0)
    else $error("result produced after status");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RUN |-> run_r != 8'd0)
    else $error("run phase with empty run count");

  a_run_advance: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_RUN |=> cursor_r == $past(cursor_r) + 32'd1)
    else $error("cursor did not advance on run byte");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> !push.first.is_status && push.second.is_status)
    else $error("two results not pixel then status");

endmodule

>>> rtl/ramd_res_fifo.sv
module ramd_res_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  ramd_pkg::push_t push,
  output logic            room,
  output logic            out_vld,
  input  logic            out_rdy,
  output ramd_pkg::res_t  out_res
);
  import ramd_pkg::*;

  res_t       mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  // two free slots needed, since one beat can bring two results
  assign room    = count_r <= 3'd2;
  assign out_vld = count_r != 3'd0;
  assign out_res = mem[rd_ptr_r];
  assign pop     = out_vld & out_rdy;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr_r] <= push.first;
    if (push.cnt == 2'd2) mem[wr_ptr_r + 2'd1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> count_r <= 3'd2)
    else $error("push without room");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[1:0] == wr_ptr_r - rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

>>> rtl/rle_alpha_mask_decoder.sv
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------
// input    | in_valid/in_ready   | in_code_byte
// result   | out_valid/out_ready | out_is_status .. out_last_result
// config   | psel/penable/pwrite | paddr, pwdata, prdata (pready tied high)
//
// one byte per cycle unless stalled: input register -> decode logic -> 4-entry result queue
// a byte giving a pixel and the stream status needs two result beats
// a byte passes the input register, then its first result beat is written into the queue
// synchronous active-low reset, no clearing pass; in_ready drops while a byte waits and the
// queue has fewer than two free entries, so stalls on out_ready back up into in_ready
module rle_alpha_mask_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_code_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_status,
  output logic [31:0] out_pixel_index,
  output logic [7:0]  out_alpha_value,
  output logic [2:0]  out_error_code,
  output logic [ramd_pkg::LEN_BITS-1:0] out_bytes_used,
  output logic [31:0] out_end_cursor,
  output logic        out_last_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ramd_pkg::*;

  logic [15:0]         width_r, height_r;
  logic [LEN_BITS-1:0] len_r;
  logic [31:0]         pix_total_r;
  logic                in_vld_r;
  logic [7:0]          in_byte_r;
  logic                take, room, wr_en;
  reg_idx_t            reg_idx;
  push_t               push;
  res_t                res;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    prdata = 32'd0;
    case (reg_idx)
      REG_WIDTH:  prdata = {16'd0, width_r};
      REG_HEIGHT: prdata = {16'd0, height_r};
      REG_LENGTH: prdata = 32'(len_r);
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 16'd0;
      height_r    <= 16'd0;
      len_r       <= LEN_BITS'(1);
      pix_total_r <= 32'd0;
    end else begin
      if (wr_en && reg_idx == REG_WIDTH)  width_r  <= pwdata[15:0];
      if (wr_en && reg_idx == REG_HEIGHT) height_r <= pwdata[15:0];
      if (wr_en && reg_idx == REG_LENGTH) len_r    <= pwdata[LEN_BITS-1:0];
      pix_total_r <= 32'(width_r) * 32'(height_r);
    end
  end

  // input register
  assign in_ready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_byte_r <= in_code_byte;
  end

  ramd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_vld_r),
    .in_byte    (in_byte_r),
    .room       (room),
    .pix_total  (pix_total_r),
    .stream_len (len_r),
    .take       (take),
    .push       (push)
  );

  ramd_res_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .out_vld (out_valid),
    .out_rdy (out_ready),
    .out_res (res)
  );

  assign out_is_status       = res.is_status;
  assign out_pixel_index     = res.pixel_index;
  assign out_alpha_value     = res.alpha_value;
  assign out_error_code      = res.error_code;
  assign out_bytes_used      = res.bytes_used;
  assign out_end_cursor      = res.end_cursor;
  assign out_last_result     = res.last_result;

endmodule
